>>> rtl/core/des_pkg.sv
// Shared widths, register indexes and types for the DES block cipher.
package des_pkg;

    localparam int unsigned BLOCK_W    = 64;
    localparam int unsigned HALF_W     = 32;
    localparam int unsigned KEY_W      = 64;
    localparam int unsigned SUBKEY_W   = 48;
    localparam int unsigned NUM_ROUNDS = 16;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_CIPHER_KEY   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT_MODE = 1'b1;

    typedef logic [SUBKEY_W-1:0] subkey_t;
    typedef subkey_t subkey_arr_t [NUM_ROUNDS];

endpackage

>>> rtl/core/des_block_cipher_ecb.sv
// Top level of the DES electronic-codebook cipher with its handshake and configuration registers.
//
// The input channel (s_valid, s_ready, s_block_in) takes one 64-bit block per
// transaction, first byte in the most significant bits. The result channel
// (m_valid, m_ready, m_block_out) returns the enciphered or deciphered block,
// one result transaction per input transaction and in the same order.
// The key (index 0) and the direction (index 1, bit 0 only) are to be written
// through cfg_wr_en, cfg_index and cfg_wdata while no transaction is in flight;
// the block itself does not enforce this. An accepted block is held in an input
// register; the initial permutation, all sixteen unrolled rounds and the final
// permutation lie between it and the result register, which loads the block when
// empty or when m_ready is high. While m_ready stays high, a new block can be
// accepted every cycle. When the receiver stalls, the result register holds its
// block and one more block may wait in the input register; s_ready then falls
// until m_ready returns. Reset clears both stages, the key and the direction.
module des_block_cipher_ecb import des_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [BLOCK_W-1:0]    s_block_in,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [BLOCK_W-1:0]    m_block_out,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam logic [6:0] IP_TAB [64] = '{
        7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
        7'd60, 7'd52, 7'd44, 7'd36, 7'd28, 7'd20, 7'd12, 7'd4,
        7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,
        7'd64, 7'd56, 7'd48, 7'd40, 7'd32, 7'd24, 7'd16, 7'd8,
        7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
        7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
        7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21, 7'd13, 7'd5,
        7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7
    };

    localparam logic [6:0] FP_TAB [64] = '{
        7'd40, 7'd8, 7'd48, 7'd16, 7'd56, 7'd24, 7'd64, 7'd32,
        7'd39, 7'd7, 7'd47, 7'd15, 7'd55, 7'd23, 7'd63, 7'd31,
        7'd38, 7'd6, 7'd46, 7'd14, 7'd54, 7'd22, 7'd62, 7'd30,
        7'd37, 7'd5, 7'd45, 7'd13, 7'd53, 7'd21, 7'd61, 7'd29,
        7'd36, 7'd4, 7'd44, 7'd12, 7'd52, 7'd20, 7'd60, 7'd28,
        7'd35, 7'd3, 7'd43, 7'd11, 7'd51, 7'd19, 7'd59, 7'd27,
        7'd34, 7'd2, 7'd42, 7'd10, 7'd50, 7'd18, 7'd58, 7'd26,
        7'd33, 7'd1, 7'd41, 7'd9,  7'd49, 7'd17, 7'd57, 7'd25
    };

    function automatic logic [63:0] perm64(input logic [63:0] x, input logic [6:0] t [64]);
        logic [63:0] y;
        logic [5:0]  idx;
        for (int i = 0; i < 64; i++) begin
            idx       = 6'(7'd64 - t[i]);
            y[63 - i] = x[idx];
        end
        return y;
    endfunction

    logic                in_valid_reg;
    logic [BLOCK_W-1:0]  in_blk_reg;
    logic                out_valid_reg;
    logic [BLOCK_W-1:0]  out_blk_reg;
    logic [KEY_W-1:0]    key_reg;
    logic                decrypt_reg;
    logic                advance;
    logic [BLOCK_W-1:0]  ip_blk;
    logic [BLOCK_W-1:0]  result;
    logic [HALF_W-1:0]   l_chain [NUM_ROUNDS + 1];
    logic [HALF_W-1:0]   r_chain [NUM_ROUNDS + 1];
    subkey_arr_t         subkeys;

    assign advance     = !out_valid_reg || m_ready;
    assign s_ready     = !in_valid_reg || advance;
    assign m_valid     = out_valid_reg;
    assign m_block_out = out_blk_reg;

    des_keysched u_keysched (
        .key     (key_reg),
        .decrypt (decrypt_reg),
        .subkeys (subkeys)
    );

    assign ip_blk     = perm64(in_blk_reg, IP_TAB);
    assign l_chain[0] = ip_blk[63:32];
    assign r_chain[0] = ip_blk[31:0];

    for (genvar gi = 0; gi < NUM_ROUNDS; gi++) begin : g_round
        des_round u_round (
            .l_in   (l_chain[gi]),
            .r_in   (r_chain[gi]),
            .subkey (subkeys[gi]),
            .l_out  (l_chain[gi + 1]),
            .r_out  (r_chain[gi + 1])
        );
    end

    assign result = perm64({r_chain[NUM_ROUNDS], l_chain[NUM_ROUNDS]}, FP_TAB);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            key_reg       <= '0;
            decrypt_reg   <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_CIPHER_KEY:   key_reg     <= cfg_wdata;
                    CFG_DECRYPT_MODE: decrypt_reg <= cfg_wdata[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_blk_reg <= s_block_in;
        end
        if (advance && in_valid_reg) begin
            out_blk_reg <= result;
        end
    end

    a_input_moves_on: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && advance) |=> m_valid)
        else $error("A block in the input register did not reach the result register.");

    a_ready_low_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready))
        else $error("Input held off while a stage was free.");

    a_accept_fills_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> in_valid_reg)
        else $error("An accepted transaction was not captured in the input register.");

endmodule

>>> rtl/core/des_keysched.sv
// DES key schedule: sixteen subkeys from the key, in round order for the selected direction.
module des_keysched import des_pkg::*; (
    input  logic [KEY_W-1:0] key,
    input  logic             decrypt,
    output subkey_arr_t      subkeys
);

    localparam logic [6:0] PC1_TAB [56] = '{
        7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
        7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
        7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
        7'd60, 7'd52, 7'd44, 7'd36,
        7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7,
        7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,
        7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21, 7'd13, 7'd5,
        7'd28, 7'd20, 7'd12, 7'd4
    };

    localparam logic [5:0] PC2_TAB [48] = '{
        6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,  6'd3,  6'd28,
        6'd15, 6'd6,  6'd21, 6'd10, 6'd23, 6'd19, 6'd12, 6'd4,
        6'd26, 6'd8,  6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
        6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55, 6'd30, 6'd40,
        6'd51, 6'd45, 6'd33, 6'd48, 6'd44, 6'd49, 6'd39, 6'd56,
        6'd34, 6'd53, 6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
    };

    // Total left rotation of each half after each round's shift.
    localparam logic [4:0] ROT_TAB [16] = '{
        5'd1,  5'd2,  5'd4,  5'd6,  5'd8,  5'd10, 5'd12, 5'd14,
        5'd15, 5'd17, 5'd19, 5'd21, 5'd23, 5'd25, 5'd27, 5'd28
    };

    function automatic logic [55:0] perm_pc1(input logic [63:0] x);
        logic [55:0] y;
        logic [5:0]  idx;
        for (int i = 0; i < 56; i++) begin
            idx       = 6'(7'd64 - PC1_TAB[i]);
            y[55 - i] = x[idx];
        end
        return y;
    endfunction

    function automatic logic [47:0] perm_pc2(input logic [55:0] x);
        logic [47:0] y;
        logic [5:0]  idx;
        for (int i = 0; i < 48; i++) begin
            idx       = 6'd56 - PC2_TAB[i];
            y[47 - i] = x[idx];
        end
        return y;
    endfunction

    function automatic logic [27:0] rotl28(input logic [27:0] v, input logic [4:0] d);
        return (v << d) | (v >> (5'd28 - d));
    endfunction

    logic [55:0] k56;
    logic [27:0] c0;
    logic [27:0] d0;
    subkey_arr_t enc_keys;

    assign k56 = perm_pc1(key);
    assign c0  = k56[55:28];
    assign d0  = k56[27:0];

    always_comb begin
        for (int i = 0; i < NUM_ROUNDS; i++) begin
            enc_keys[i] = perm_pc2({rotl28(c0, ROT_TAB[i]), rotl28(d0, ROT_TAB[i])});
        end
        for (int i = 0; i < NUM_ROUNDS; i++) begin
            subkeys[i] = decrypt ? enc_keys[NUM_ROUNDS - 1 - i] : enc_keys[i];
        end
    end

endmodule

>>> rtl/core/des_round.sv
// One DES Feistel round: expansion, key mixing, S-boxes and the P permutation.
module des_round import des_pkg::*; (
    input  logic [HALF_W-1:0] l_in,
    input  logic [HALF_W-1:0] r_in,
    input  subkey_t           subkey,
    output logic [HALF_W-1:0] l_out,
    output logic [HALF_W-1:0] r_out
);

    localparam logic [5:0] E_TAB [48] = '{
        6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd4,  6'd5,
        6'd6,  6'd7,  6'd8,  6'd9,  6'd8,  6'd9,  6'd10, 6'd11,
        6'd12, 6'd13, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
        6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd20, 6'd21,
        6'd22, 6'd23, 6'd24, 6'd25, 6'd24, 6'd25, 6'd26, 6'd27,
        6'd28, 6'd29, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
    };

    localparam logic [5:0] P_TAB [32] = '{
        6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
        6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
        6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
        6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
    };

    localparam logic [3:0] SBOX [8][64] = '{
        '{4'd14, 4'd4, 4'd13, 4'd1, 4'd2, 4'd15, 4'd11, 4'd8,
          4'd3, 4'd10, 4'd6, 4'd12, 4'd5, 4'd9, 4'd0, 4'd7,
          4'd0, 4'd15, 4'd7, 4'd4, 4'd14, 4'd2, 4'd13, 4'd1,
          4'd10, 4'd6, 4'd12, 4'd11, 4'd9, 4'd5, 4'd3, 4'd8,
          4'd4, 4'd1, 4'd14, 4'd8, 4'd13, 4'd6, 4'd2, 4'd11,
          4'd15, 4'd12, 4'd9, 4'd7, 4'd3, 4'd10, 4'd5, 4'd0,
          4'd15, 4'd12, 4'd8, 4'd2, 4'd4, 4'd9, 4'd1, 4'd7,
          4'd5, 4'd11, 4'd3, 4'd14, 4'd10, 4'd0, 4'd6, 4'd13},
        '{4'd15, 4'd1, 4'd8, 4'd14, 4'd6, 4'd11, 4'd3, 4'd4,
          4'd9, 4'd7, 4'd2, 4'd13, 4'd12, 4'd0, 4'd5, 4'd10,
          4'd3, 4'd13, 4'd4, 4'd7, 4'd15, 4'd2, 4'd8, 4'd14,
          4'd12, 4'd0, 4'd1, 4'd10, 4'd6, 4'd9, 4'd11, 4'd5,
          4'd0, 4'd14, 4'd7, 4'd11, 4'd10, 4'd4, 4'd13, 4'd1,
          4'd5, 4'd8, 4'd12, 4'd6, 4'd9, 4'd3, 4'd2, 4'd15,
          4'd13, 4'd8, 4'd10, 4'd1, 4'd3, 4'd15, 4'd4, 4'd2,
          4'd11, 4'd6, 4'd7, 4'd12, 4'd0, 4'd5, 4'd14, 4'd9},
        '{4'd10, 4'd0, 4'd9, 4'd14, 4'd6, 4'd3, 4'd15, 4'd5,
          4'd1, 4'd13, 4'd12, 4'd7, 4'd11, 4'd4, 4'd2, 4'd8,
          4'd13, 4'd7, 4'd0, 4'd9, 4'd3, 4'd4, 4'd6, 4'd10,
          4'd2, 4'd8, 4'd5, 4'd14, 4'd12, 4'd11, 4'd15, 4'd1,
          4'd13, 4'd6, 4'd4, 4'd9, 4'd8, 4'd15, 4'd3, 4'd0,
          4'd11, 4'd1, 4'd2, 4'd12, 4'd5, 4'd10, 4'd14, 4'd7,
          4'd1, 4'd10, 4'd13, 4'd0, 4'd6, 4'd9, 4'd8, 4'd7,
          4'd4, 4'd15, 4'd14, 4'd3, 4'd11, 4'd5, 4'd2, 4'd12},
        '{4'd7, 4'd13, 4'd14, 4'd3, 4'd0, 4'd6, 4'd9, 4'd10,
          4'd1, 4'd2, 4'd8, 4'd5, 4'd11, 4'd12, 4'd4, 4'd15,
          4'd13, 4'd8, 4'd11, 4'd5, 4'd6, 4'd15, 4'd0, 4'd3,
          4'd4, 4'd7, 4'd2, 4'd12, 4'd1, 4'd10, 4'd14, 4'd9,
          4'd10, 4'd6, 4'd9, 4'd0, 4'd12, 4'd11, 4'd7, 4'd13,
          4'd15, 4'd1, 4'd3, 4'd14, 4'd5, 4'd2, 4'd8, 4'd4,
          4'd3, 4'd15, 4'd0, 4'd6, 4'd10, 4'd1, 4'd13, 4'd8,
          4'd9, 4'd4, 4'd5, 4'd11, 4'd12, 4'd7, 4'd2, 4'd14},
        '{4'd2, 4'd12, 4'd4, 4'd1, 4'd7, 4'd10, 4'd11, 4'd6,
          4'd8, 4'd5, 4'd3, 4'd15, 4'd13, 4'd0, 4'd14, 4'd9,
          4'd14, 4'd11, 4'd2, 4'd12, 4'd4, 4'd7, 4'd13, 4'd1,
          4'd5, 4'd0, 4'd15, 4'd10, 4'd3, 4'd9, 4'd8, 4'd6,
          4'd4, 4'd2, 4'd1, 4'd11, 4'd10, 4'd13, 4'd7, 4'd8,
          4'd15, 4'd9, 4'd12, 4'd5, 4'd6, 4'd3, 4'd0, 4'd14,
          4'd11, 4'd8, 4'd12, 4'd7, 4'd1, 4'd14, 4'd2, 4'd13,
          4'd6, 4'd15, 4'd0, 4'd9, 4'd10, 4'd4, 4'd5, 4'd3},
        '{4'd12, 4'd1, 4'd10, 4'd15, 4'd9, 4'd2, 4'd6, 4'd8,
          4'd0, 4'd13, 4'd3, 4'd4, 4'd14, 4'd7, 4'd5, 4'd11,
          4'd10, 4'd15, 4'd4, 4'd2, 4'd7, 4'd12, 4'd9, 4'd5,
          4'd6, 4'd1, 4'd13, 4'd14, 4'd0, 4'd11, 4'd3, 4'd8,
          4'd9, 4'd14, 4'd15, 4'd5, 4'd2, 4'd8, 4'd12, 4'd3,
          4'd7, 4'd0, 4'd4, 4'd10, 4'd1, 4'd13, 4'd11, 4'd6,
          4'd4, 4'd3, 4'd2, 4'd12, 4'd9, 4'd5, 4'd15, 4'd10,
          4'd11, 4'd14, 4'd1, 4'd7, 4'd6, 4'd0, 4'd8, 4'd13},
        '{4'd4, 4'd11, 4'd2, 4'd14, 4'd15, 4'd0, 4'd8, 4'd13,
          4'd3, 4'd12, 4'd9, 4'd7, 4'd5, 4'd10, 4'd6, 4'd1,
          4'd13, 4'd0, 4'd11, 4'd7, 4'd4, 4'd9, 4'd1, 4'd10,
          4'd14, 4'd3, 4'd5, 4'd12, 4'd2, 4'd15, 4'd8, 4'd6,
          4'd1, 4'd4, 4'd11, 4'd13, 4'd12, 4'd3, 4'd7, 4'd14,
          4'd10, 4'd15, 4'd6, 4'd8, 4'd0, 4'd5, 4'd9, 4'd2,
          4'd6, 4'd11, 4'd13, 4'd8, 4'd1, 4'd4, 4'd10, 4'd7,
          4'd9, 4'd5, 4'd0, 4'd15, 4'd14, 4'd2, 4'd3, 4'd12},
        '{4'd13, 4'd2, 4'd8, 4'd4, 4'd6, 4'd15, 4'd11, 4'd1,
          4'd10, 4'd9, 4'd3, 4'd14, 4'd5, 4'd0, 4'd12, 4'd7,
          4'd1, 4'd15, 4'd13, 4'd8, 4'd10, 4'd3, 4'd7, 4'd4,
          4'd12, 4'd5, 4'd6, 4'd11, 4'd0, 4'd14, 4'd9, 4'd2,
          4'd7, 4'd11, 4'd4, 4'd1, 4'd9, 4'd12, 4'd14, 4'd2,
          4'd0, 4'd6, 4'd10, 4'd13, 4'd15, 4'd3, 4'd5, 4'd8,
          4'd2, 4'd1, 4'd14, 4'd7, 4'd4, 4'd10, 4'd8, 4'd13,
          4'd15, 4'd12, 4'd9, 4'd0, 4'd3, 4'd5, 4'd6, 4'd11}
    };

    logic [SUBKEY_W-1:0] mixed;
    logic [HALF_W-1:0]   sbox_out;
    logic [HALF_W-1:0]   f_out;

    always_comb begin
        logic [4:0] idx;
        logic [5:0] six;
        for (int i = 0; i < 48; i++) begin
            idx           = 5'(6'd32 - E_TAB[i]);
            mixed[47 - i] = r_in[idx] ^ subkey[47 - i];
        end
        for (int s = 0; s < 8; s++) begin
            six                    = mixed[47 - 6 * s -: 6];
            sbox_out[31 - 4 * s -: 4] = SBOX[s][{six[5], six[0], six[4:1]}];
        end
        for (int i = 0; i < 32; i++) begin
            idx           = 5'(6'd32 - P_TAB[i]);
            f_out[31 - i] = sbox_out[idx];
        end
    end

    assign l_out = r_in;
    assign r_out = l_in ^ f_out;

endmodule
